// ===== hdl/assert_macros.svh =====
// assertion helpers used by the checker in tgarle_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock edge out of reset
`define TGARLE_ASSERT(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TGARLE_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/tgarle_pkg.sv =====
package tgarle_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [2:0] CFG_BYTES_PER_PIXEL = 3'd2;
    localparam logic [2:0] CFG_RLE_ENABLE      = 3'd3;
    localparam logic [2:0] CFG_FLIP_ROWS       = 3'd4;
    localparam logic [2:0] CFG_SWAP_RED_BLUE   = 3'd5;

    localparam int CFG_DIM_BITS = 13;

    // register reset values and minimum geometry
    localparam int RESET_WIDTH  = 4;
    localparam int RESET_HEIGHT = 1;
    localparam int MIN_WIDTH    = 4;
    localparam int MIN_HEIGHT   = 1;

    localparam logic [2:0] BPP_RGB  = 3'd3;
    localparam logic [2:0] BPP_RGBA = 3'd4;

    // packet header layout
    localparam int HDR_REPEAT_BIT = 7;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_EMIT    = 3'b010,
        ST_RESTART = 3'b100
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic restart;
        logic take_byte;
        logic emit_span;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cfg_hit;
        logic pix_done;
        logic out_free;
        logic span_last;
    } status_t;

endpackage

// ===== hdl/tgarle_dp.sv =====
module tgarle_dp #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tgarle_pkg::cmd_t                      cmd,
    output tgarle_pkg::status_t                   status,
    input  logic [7:0]                            s_in_byte,
    input  logic                                  cfg_valid,
    input  logic [2:0]                            cfg_index,
    input  logic [tgarle_pkg::CFG_DIM_BITS-1:0]   cfg_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [23:0]                           m_pixel_address,
    output logic [7:0]                            m_span_length,
    output logic [7:0]                            m_chan0,
    output logic [7:0]                            m_chan1,
    output logic [7:0]                            m_chan2,
    output logic [7:0]                            m_chan3,
    output logic                                  m_frame_done,
    output logic                                  m_last_span
);
    import tgarle_pkg::*;

    localparam int DIM_MAX = (1 << CFG_DIM_BITS) - 1;
    localparam int WMAX  = (MAX_WIDTH  < DIM_MAX) ? MAX_WIDTH  : DIM_MAX;
    localparam int HMAX  = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
    localparam int WBITS = $clog2(WMAX + 1);
    localparam int HBITS = $clog2(HMAX + 1);
    localparam int CBITS = $clog2(WMAX);
    localparam int PBITS = WBITS + HBITS;
    localparam int LW    = (WBITS > 8) ? WBITS : 8;
    localparam int DW    = (PBITS > 8) ? PBITS : 8;
    localparam int AW    = (PBITS > 24) ? PBITS : 24;

    // configuration registers
    logic [CFG_DIM_BITS-1:0] width_reg, height_reg;
    logic [2:0]              bpp_reg;
    logic                    rle_reg, flip_reg, swap_reg;

    // decoder state
    logic             expect_reg, expect_next;
    logic             repeat_reg, repeat_next;
    logic [7:0]       remaining_reg, remaining_next;
    logic [1:0]       bip_reg, bip_next;
    logic [31:0]      pix_reg, pix_next;
    logic [CBITS-1:0] column_reg, column_next;
    logic [PBITS-1:0] row_base_reg, row_base_next;
    logic [PBITS-1:0] left_reg, left_next;
    logic             done_reg, done_next;
    logic [7:0]       count_reg, count_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [23:0]      addr_reg;
    logic [7:0]       len_reg;
    logic [7:0]       ch0_reg, ch1_reg, ch2_reg, ch3_reg;
    logic             fdone_reg, last_reg;

    logic [CFG_DIM_BITS-1:0] w_clamp, h_clamp;
    logic [WBITS-1:0]        eff_w, room, col_sum;
    logic [HBITS-1:0]        eff_h, h_m1;
    logic [PBITS-1:0]        geo_prod, geo_total;
    logic                    cfg_hit, last_byte, hdr_byte;
    logic [LW-1:0]           count_l, room_l, len_l;
    logic [7:0]              span_len;
    logic                    row_end, done_now;
    logic [DW-1:0]           left_d, len_d, left_after;
    logic [AW-1:0]           addr_full;
    logic [7:0]              b0, b1, b2, b3;
    logic [7:0]              rem_dec;

    // clamped geometry and start of frame
    always_comb begin
        w_clamp = (width_reg < CFG_DIM_BITS'(MIN_WIDTH)) ? CFG_DIM_BITS'(MIN_WIDTH) :
                  (width_reg > CFG_DIM_BITS'(WMAX)) ? CFG_DIM_BITS'(WMAX) : width_reg;
        h_clamp = (height_reg < CFG_DIM_BITS'(MIN_HEIGHT)) ? CFG_DIM_BITS'(MIN_HEIGHT) :
                  (height_reg > CFG_DIM_BITS'(HMAX)) ? CFG_DIM_BITS'(HMAX) : height_reg;
        eff_w     = w_clamp[WBITS-1:0];
        eff_h     = h_clamp[HBITS-1:0];
        h_m1      = eff_h - HBITS'(1);
        geo_prod  = PBITS'(h_m1) * PBITS'(eff_w);
        geo_total = geo_prod + PBITS'(eff_w);
    end

    assign cfg_hit = cfg_valid && (cfg_index <= CFG_SWAP_RED_BLUE);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_DIM_BITS'(RESET_WIDTH);
            height_reg <= CFG_DIM_BITS'(RESET_HEIGHT);
            bpp_reg    <= BPP_RGBA;
            rle_reg    <= 1'b1;
            flip_reg   <= 1'b0;
            swap_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:     width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:    height_reg <= cfg_data;
                CFG_BYTES_PER_PIXEL: bpp_reg    <= cfg_data[2:0];
                CFG_RLE_ENABLE:      rle_reg    <= cfg_data[0];
                CFG_FLIP_ROWS:       flip_reg   <= cfg_data[0];
                CFG_SWAP_RED_BLUE:   swap_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // byte classification
    assign hdr_byte  = rle_reg && expect_reg;
    assign last_byte = (bpp_reg == BPP_RGB) ? (bip_reg == 2'd2) : (bip_reg == 2'd3);
    assign rem_dec   = (remaining_reg != 8'd0) ? remaining_reg - 8'd1 : 8'd0;

    // span arithmetic for the current run
    always_comb begin
        room       = eff_w - WBITS'(column_reg);
        count_l    = LW'(count_reg);
        room_l     = LW'(room);
        len_l      = (count_l < room_l) ? count_l : room_l;
        span_len   = len_l[7:0];
        col_sum    = WBITS'(column_reg) + len_l[WBITS-1:0];
        row_end    = (col_sum == eff_w);
        left_d     = DW'(left_reg);
        len_d      = DW'(span_len);
        done_now   = (left_d <= len_d);
        left_after = left_d - len_d;
        addr_full  = AW'(row_base_reg) + AW'(column_reg);
        b0 = swap_reg ? pix_reg[23:16] : pix_reg[7:0];
        b1 = pix_reg[15:8];
        b2 = swap_reg ? pix_reg[7:0] : pix_reg[23:16];
        b3 = (bpp_reg == BPP_RGB) ? 8'd0 : pix_reg[31:24];
    end

    // state update
    always_comb begin
        expect_next    = expect_reg;
        repeat_next    = repeat_reg;
        remaining_next = remaining_reg;
        bip_next       = bip_reg;
        pix_next       = pix_reg;
        column_next    = column_reg;
        row_base_next  = row_base_reg;
        left_next      = left_reg;
        done_next      = done_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (cmd.restart) begin
            expect_next    = 1'b1;
            repeat_next    = 1'b0;
            remaining_next = 8'd0;
            bip_next       = 2'd0;
            column_next    = '0;
            row_base_next  = flip_reg ? geo_prod : '0;
            left_next      = geo_total;
            done_next      = 1'b0;
        end else if (cmd.take_byte && !done_reg) begin
            if (hdr_byte) begin
                // packet header
                repeat_next    = s_in_byte[HDR_REPEAT_BIT];
                remaining_next = {1'b0, s_in_byte[6:0]} + 8'd1;
                expect_next    = 1'b0;
                bip_next       = 2'd0;
            end else begin
                // pixel byte
                pix_next[{bip_reg, 3'b000} +: 8] = s_in_byte;
                bip_next = last_byte ? 2'd0 : bip_reg + 2'd1;
                if (last_byte) begin
                    if (!rle_reg) begin
                        count_next = 8'd1;
                    end else if (repeat_reg) begin
                        count_next     = remaining_reg;
                        remaining_next = 8'd0;
                        expect_next    = 1'b1;
                    end else begin
                        count_next     = 8'd1;
                        remaining_next = rem_dec;
                        expect_next    = (rem_dec == 8'd0);
                    end
                end
            end
        end else if (cmd.emit_span) begin
            // one span of the run into the output register
            m_valid_next = 1'b1;
            count_next   = count_reg - span_len;
            left_next    = left_after[PBITS-1:0];
            done_next    = done_now;
            if (row_end) begin
                column_next = '0;
                if (flip_reg) begin
                    row_base_next = (row_base_reg >= PBITS'(eff_w)) ?
                                    row_base_reg - PBITS'(eff_w) : '0;
                end else begin
                    row_base_next = row_base_reg + PBITS'(eff_w);
                end
            end else begin
                column_next = col_sum[CBITS-1:0];
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_reg    <= 1'b1;
            repeat_reg    <= 1'b0;
            remaining_reg <= 8'd0;
            bip_reg       <= 2'd0;
            column_reg    <= '0;
            row_base_reg  <= '0;
            left_reg      <= PBITS'(RESET_WIDTH * RESET_HEIGHT);
            done_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            expect_reg    <= expect_next;
            repeat_reg    <= repeat_next;
            remaining_reg <= remaining_next;
            bip_reg       <= bip_next;
            column_reg    <= column_next;
            row_base_reg  <= row_base_next;
            left_reg      <= left_next;
            done_reg      <= done_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pix_reg   <= pix_next;
        count_reg <= count_next;
        if (cmd.emit_span) begin
            addr_reg  <= addr_full[23:0];
            len_reg   <= span_len;
            ch0_reg   <= b0;
            ch1_reg   <= b1;
            ch2_reg   <= b2;
            ch3_reg   <= b3;
            fdone_reg <= done_now;
            last_reg  <= (count_l <= room_l) || done_now;
        end
    end

    always_comb begin
        status.cfg_hit   = cfg_hit;
        status.pix_done  = !done_reg && !hdr_byte && last_byte;
        status.out_free  = !m_valid_reg || m_ready;
        status.span_last = (count_l <= room_l) || done_now;
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_address = addr_reg;
    assign m_span_length   = len_reg;
    assign m_chan0         = ch0_reg;
    assign m_chan1         = ch1_reg;
    assign m_chan2         = ch2_reg;
    assign m_chan3         = ch3_reg;
    assign m_frame_done    = fdone_reg;
    assign m_last_span     = last_reg;

endmodule

// ===== hdl/tgarle_ctrl.sv =====
module tgarle_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tgarle_pkg::status_t status,
    output tgarle_pkg::cmd_t    cmd
);
    import tgarle_pkg::*;

    state_t state_reg, state_next;

    // sequencing of byte intake, span output and frame restart
    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd.restart   = 1'b0;
        cmd.take_byte = 1'b0;
        cmd.emit_span = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.take_byte = s_valid;
                if (s_valid && status.pix_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.emit_span = status.out_free;
                if (status.out_free && status.span_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESTART: begin
                cmd.restart = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (status.cfg_hit) begin
            state_next = ST_RESTART;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/tga_rle_pixel_decoder_core.sv =====
// channel  | direction | payload                                        | handshake
// s_       | in        | in_byte                                        | s_valid / s_ready
// m_       | out       | pixel_address, span_length, chan0..3, flags    | m_valid / m_ready
// cfg_     | in        | cfg_index (register), cfg_data                 | cfg_valid / cfg_ready
//
// header bytes and bytes inside a pixel keep the controller in ST_IDLE with s_ready high
// a byte that ends a pixel moves the controller to ST_EMIT, which issues its spans (1 to 33) one by one
// a register write is followed by the ST_RESTART state with s_ready low (frame geometry multiply)
// reset restores register defaults and an empty frame at once
// a stalled m_ready holds ST_EMIT; s_ready is high only in ST_IDLE, low while spans go out and during a restart
module tga_rle_pixel_decoder_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_in_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [23:0]                         m_pixel_address,
    output logic [7:0]                          m_span_length,
    output logic [7:0]                          m_chan0,
    output logic [7:0]                          m_chan1,
    output logic [7:0]                          m_chan2,
    output logic [7:0]                          m_chan3,
    output logic                                m_frame_done,
    output logic                                m_last_span,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [2:0]                          cfg_index,
    input  logic [tgarle_pkg::CFG_DIM_BITS-1:0] cfg_data
);
    import tgarle_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    tgarle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tgarle_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_in_byte       (s_in_byte),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_span_length   (m_span_length),
        .m_chan0         (m_chan0),
        .m_chan1         (m_chan1),
        .m_chan2         (m_chan2),
        .m_chan3         (m_chan3),
        .m_frame_done    (m_frame_done),
        .m_last_span     (m_last_span)
    );

endmodule

// ===== hdl/tgarle_checker.sv =====
`include "assert_macros.svh"

module tgarle_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [23:0] m_pixel_address,
    input logic [7:0]  m_span_length,
    input logic        m_frame_done,
    input logic        m_last_span
);

    // a stalled span keeps its payload
    `TGARLE_ASSERT_NEXT(a_span_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pixel_address) && $stable(m_span_length), "span changed while stalled")

    // spans cover one to 128 pixels
    `TGARLE_ASSERT(a_span_range, aclk, aresetn, !m_valid || ((m_span_length != 8'd0) && (m_span_length <= 8'd128)), "span length out of range")

    // the span that completes the frame ends its transaction group
    `TGARLE_ASSERT(a_done_last, aclk, aresetn, !(m_valid && m_frame_done) || m_last_span, "frame done without last span")

    // nothing follows the final span of a frame
    `TGARLE_ASSERT_NEXT(a_quiet_after_done, aclk, aresetn, m_valid && m_ready && m_frame_done, !m_valid, "span after frame done")

endmodule

bind tga_rle_pixel_decoder_core tgarle_checker u_tgarle_checker (.*);

// ===== dv/tga_rle_pixel_decoder_checker.sv =====
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_checker #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [7:0]                          s_in_byte,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [23:0]                         m_pixel_address,
    input  logic [7:0]                          m_span_length,
    input  logic [7:0]                          m_chan0,
    input  logic [7:0]                          m_chan1,
    input  logic [7:0]                          m_chan2,
    input  logic [7:0]                          m_chan3,
    input  logic                                m_frame_done,
    input  logic                                m_last_span,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [2:0]                          cfg_index,
    input  logic [tgarle_pkg::CFG_DIM_BITS-1:0] cfg_data,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  bytes_taken,
    output int                                  spans_seen,
    output logic                                frame_over
);

    import tgarle_pkg::*;

    typedef struct packed {
        logic [23:0] address;
        logic [7:0]  length;
        logic [7:0]  chan0;
        logic [7:0]  chan1;
        logic [7:0]  chan2;
        logic [7:0]  chan3;
        logic        frame_done;
        logic        last_span;
    } pixel_span_t;

    // spans still owed by the block, oldest first
    pixel_span_t spans_due[$];

    // register copies
    logic [CFG_DIM_BITS-1:0] reg_width;
    logic [CFG_DIM_BITS-1:0] reg_height;
    logic [2:0]              reg_bpp;
    logic                    reg_rle;
    logic                    reg_flip;
    logic                    reg_swap;

    // decoder state
    logic        want_header;
    logic        run_is_repeat;
    logic        frame_full;
    int unsigned run_left;
    int unsigned byte_pos;
    logic [31:0] pixel_word;
    int unsigned col;
    int unsigned row_start;
    int unsigned written;

    function automatic int unsigned width_used();
        int unsigned w;
        w = reg_width;
        if (w < MIN_WIDTH) w = MIN_WIDTH;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned height_used();
        int unsigned h;
        h = reg_height;
        if (h < MIN_HEIGHT) h = MIN_HEIGHT;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic int unsigned bpp_used();
        return (reg_bpp == BPP_RGB) ? 3 : 4;
    endfunction

    // empty frame, registers kept
    task automatic restart_frame();
        want_header   = 1'b1;
        run_is_repeat = 1'b0;
        run_left      = 0;
        byte_pos      = 0;
        pixel_word    = '0;
        col           = 0;
        row_start     = reg_flip ? (height_used() - 1) * width_used() : 0;
        written       = 0;
        frame_full    = 1'b0;
    endtask

    // repeat the assembled pixel count times, cut at row ends
    task automatic emit_spans(input int unsigned count);
        pixel_span_t span;
        int unsigned w;
        int unsigned total;
        int unsigned room;
        int unsigned len;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        w     = width_used();
        total = w * height_used();
        b0    = pixel_word[7:0];
        b1    = pixel_word[15:8];
        b2    = pixel_word[23:16];
        b3    = (bpp_used() == 4) ? pixel_word[31:24] : 8'h00;
        if (reg_swap) begin
            b0 = pixel_word[23:16];
            b2 = pixel_word[7:0];
        end
        while (count > 0 && !frame_full) begin
            room             = w - col;
            len              = (count < room) ? count : room;
            span.address     = 24'(row_start + col);
            span.length      = 8'(len);
            span.chan0       = b0;
            span.chan1       = b1;
            span.chan2       = b2;
            span.chan3       = b3;
            span.frame_done  = 1'b0;
            written         += len;
            col             += len;
            count           -= len;
            if (col >= w) begin
                col = 0;
                if (reg_flip)
                    row_start = (row_start >= w) ? row_start - w : 0;
                else
                    row_start += w;
            end
            if (written >= total) begin
                frame_full      = 1'b1;
                span.frame_done = 1'b1;
            end
            span.last_span = (count == 0) || frame_full;
            spans_due.push_back(span);
        end
    endtask

    // one stream byte through the packet and pixel logic
    task automatic decode_byte(input logic [7:0] value);
        int unsigned count;
        if (frame_full) return;
        if (reg_rle && want_header) begin
            run_is_repeat = value[HDR_REPEAT_BIT];
            run_left      = value[6:0] + 1;
            want_header   = 1'b0;
            byte_pos      = 0;
            return;
        end
        pixel_word[byte_pos*8 +: 8] = value;
        byte_pos = (byte_pos + 1) & 3;
        if (byte_pos != 0 && byte_pos < bpp_used()) return;
        byte_pos = 0;
        if (!reg_rle) begin
            count = 1;
        end else if (run_is_repeat) begin
            count       = run_left;
            run_left    = 0;
            want_header = 1'b1;
        end else begin
            count = 1;
            if (run_left > 0) run_left--;
            if (run_left == 0) want_header = 1'b1;
        end
        emit_spans(count);
    endtask

    task automatic write_register(input logic [2:0] index,
                                  input logic [CFG_DIM_BITS-1:0] value);
        case (index)
            CFG_IMAGE_WIDTH:     reg_width  = value;
            CFG_IMAGE_HEIGHT:    reg_height = value;
            CFG_BYTES_PER_PIXEL: reg_bpp    = value[2:0];
            CFG_RLE_ENABLE:      reg_rle    = value[0];
            CFG_FLIP_ROWS:       reg_flip   = value[0];
            CFG_SWAP_RED_BLUE:   reg_swap   = value[0];
            default:             return;
        endcase
        restart_frame();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_span();
        pixel_span_t want;
        spans_seen++;
        if (spans_due.size() == 0) begin
            $error("pixel span transaction with none expected, address 0x%0h",
                   m_pixel_address);
            fail_count++;
            return;
        end
        want = spans_due.pop_front();
        check_field("pixel_address", want.address,    m_pixel_address);
        check_field("span_length",   want.length,     m_span_length);
        check_field("chan0",         want.chan0,      m_chan0);
        check_field("chan1",         want.chan1,      m_chan1);
        check_field("chan2",         want.chan2,      m_chan2);
        check_field("chan3",         want.chan3,      m_chan3);
        check_field("frame_done",    want.frame_done, m_frame_done);
        check_field("last_span",     want.last_span,  m_last_span);
    endtask

    // predictions go in before the comparison, so a same-edge result still finds them
    always @(posedge aclk) begin
        if (!aresetn) begin
            reg_width   = CFG_DIM_BITS'(RESET_WIDTH);
            reg_height  = CFG_DIM_BITS'(RESET_HEIGHT);
            reg_bpp     = BPP_RGBA;
            reg_rle     = 1'b1;
            reg_flip    = 1'b0;
            reg_swap    = 1'b0;
            restart_frame();
            spans_due.delete();
            fail_count  = 0;
            bytes_taken = 0;
            spans_seen  = 0;
        end else begin
            if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                bytes_taken++;
                decode_byte(s_in_byte);
            end
            if (m_valid && m_ready) check_span();
        end
        pending    <= spans_due.size();
        frame_over <= frame_full;
    end

endmodule

// ===== dv/tga_rle_pixel_decoder_core_test.sv =====
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_core_test;

    import tgarle_pkg::*;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_HEIGHT   = 4096;
    localparam int RANDOM_BYTES = 280;
    localparam int SETTLE       = 8;
    localparam int LIMIT        = 2500000;

    // index with no register behind it
    localparam logic [2:0] CFG_NO_REG = 3'd7;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [7:0]              s_in_byte;
    logic                    m_valid;
    logic                    m_ready;
    logic [23:0]             m_pixel_address;
    logic [7:0]              m_span_length;
    logic [7:0]              m_chan0;
    logic [7:0]              m_chan1;
    logic [7:0]              m_chan2;
    logic [7:0]              m_chan3;
    logic                    m_frame_done;
    logic                    m_last_span;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [2:0]              cfg_index;
    logic [CFG_DIM_BITS-1:0] cfg_data;

    int   fail_count;
    int   pending;
    int   bytes_taken;
    int   spans_seen;
    logic frame_over;

    int   counted     = 0;
    int   phase_end   = 0;
    int   settings    = 0;
    int   bpp_now     = 4;
    int   stall_left  = 0;
    int   cycle_count = 0;
    logic calm        = 1'b0;

    // rle mode as last written, kept on the stimulus side
    logic rle_now     = 1'b1;

    tga_rle_pixel_decoder_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_span_length   (m_span_length),
        .m_chan0         (m_chan0),
        .m_chan1         (m_chan1),
        .m_chan2         (m_chan2),
        .m_chan3         (m_chan3),
        .m_frame_done    (m_frame_done),
        .m_last_span     (m_last_span),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    tga_rle_pixel_decoder_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_span_length   (m_span_length),
        .m_chan0         (m_chan0),
        .m_chan1         (m_chan1),
        .m_chan2         (m_chan2),
        .m_chan3         (m_chan3),
        .m_frame_done    (m_frame_done),
        .m_last_span     (m_last_span),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .bytes_taken     (bytes_taken),
        .spans_seen      (spans_seen),
        .frame_over      (frame_over)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // repeat lengths, weighted towards short runs
    function automatic int pick_run();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom_range(0, 7);
        if (r < 8) return $urandom_range(8, 40);
        return $urandom_range(41, 127);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one stream byte transaction, valid held back to back when there is no gap
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (!frame_over) counted++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_pixel(input logic [31:0] pixel, input int nbytes);
        for (int i = 0; i < nbytes; i++) send_byte(pixel[8*i +: 8]);
    endtask

    // stop the stream and let every owed span come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [CFG_DIM_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [CFG_DIM_BITS-1:0] width,
                                  input logic [CFG_DIM_BITS-1:0] height,
                                  input logic [2:0] bpp, input logic rle,
                                  input logic flip, input logic swap,
                                  input logic stray_write);
        drain();
        write_reg(CFG_IMAGE_WIDTH, width);
        write_reg(CFG_IMAGE_HEIGHT, height);
        write_reg(CFG_BYTES_PER_PIXEL, {10'd0, bpp});
        write_reg(CFG_RLE_ENABLE, {12'd0, rle});
        write_reg(CFG_FLIP_ROWS, {12'd0, flip});
        write_reg(CFG_SWAP_RED_BLUE, {12'd0, swap});
        if (stray_write) write_reg(CFG_NO_REG, CFG_DIM_BITS'($urandom));
        cfg_valid <= 1'b0;
        bpp_now   = (bpp == BPP_RGB) ? 3 : 4;
        settings++;
    endtask

    // header plus pixel bytes, cut short at the phase end or a full frame
    task automatic send_rle_packet();
        logic [7:0] header;
        int         npix;
        header[7] = 1'($urandom_range(0, 1));
        if (header[7])
            header[6:0] = 7'(pick_run());
        else if ($urandom_range(0, 9) == 0)
            header[6:0] = 7'($urandom_range(0, 127));
        else
            header[6:0] = 7'($urandom_range(0, 5));
        send_byte(header);
        npix = header[7] ? 1 : header[6:0] + 1;
        for (int i = 0; i < npix * bpp_now; i++) begin
            if (frame_over || counted >= phase_end) return;
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_in_byte <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset geometry: 4x1 frame, 4-byte pixels, packets on
        send_byte(8'h81);
        send_pixel(32'hAA55FF00, 4);
        send_byte(8'h00);
        send_pixel(32'h55AA00FF, 4);
        // longest repeat run overflows the frame and ends it
        send_byte(8'hFF);
        send_pixel(32'h78563412, 4);
        // stream after the frame is complete
        send_byte(8'h3C);

        // clamped widest frame, plain 3-byte pixels, bottom-up, swapped, stray index
        rle_now = 1'b0;
        apply_settings(13'h1FFF, 13'h1FFF, BPP_RGB, 1'b0, 1'b1, 1'b1, 1'b1);
        send_pixel(32'h00030201, 3);
        send_pixel(32'h00C0B0A0, 3);

        // repeat run across three rows, flipped, odd size code read as 4 bytes
        rle_now = 1'b1;
        apply_settings(13'd5, 13'd3, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0);
        send_byte(8'h8C);
        send_pixel(32'hFFFFFFFF, 4);

        // random settings and streams
        counted = 0;
        while (counted < RANDOM_BYTES) begin
            rle_now = ($urandom_range(0, 3) != 0);
            run_phase_with_mode();
        end

        drain();
        calm = 1'b1;
        $display("covered %0d stream bytes under %0d register settings, %0d spans compared",
                 bytes_taken, settings, spans_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // register setting whose packet mode follows rle_now
    task automatic run_phase_with_mode();
        int r;
        int width;
        int height;
        int bpp;
        r = $urandom_range(0, 99);
        if (r < 70)      width = $urandom_range(4, 16);
        else if (r < 85) width = $urandom_range(0, 3);
        else if (r < 95) width = $urandom_range(17, 200);
        else             width = $urandom_range(4090, 8191);
        r = $urandom_range(0, 99);
        if (r < 70)      height = $urandom_range(1, 4);
        else if (r < 85) height = 0;
        else if (r < 95) height = $urandom_range(5, 20);
        else             height = $urandom_range(4090, 8191);
        r = $urandom_range(0, 99);
        if (r < 45)      bpp = BPP_RGB;
        else if (r < 90) bpp = BPP_RGBA;
        else             bpp = $urandom_range(0, 7);
        apply_settings(CFG_DIM_BITS'(width), CFG_DIM_BITS'(height), 3'(bpp), rle_now,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 4) == 0);
        calm      = ($urandom_range(0, 3) == 0);
        phase_end = counted + $urandom_range(12, 48);
        do begin
            if (!rle_now || $urandom_range(0, 9) == 0) begin
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 19) == 0) drain();
                send_rle_packet();
            end
        end while (counted < phase_end && !frame_over);
    endtask

endmodule
